// ===== rtl/core/m2sh_pkg.sv =====
// Shared types and codes for the MPEG-2 sequence header parser.
package m2sh_pkg;

  localparam int unsigned MatrixLen = 64;
  localparam int unsigned PosW      = $clog2(MatrixLen);
  localparam int unsigned HdrBytes  = 8;

  localparam logic [1:0] KIND_HDR      = 2'd0;
  localparam logic [1:0] KIND_INTRA    = 2'd1;
  localparam logic [1:0] KIND_NONINTRA = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } m2sh_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] pic_width;
    logic [11:0] pic_height;
    logic [3:0]  aspect_code;
    logic [3:0]  rate_code;
    logic [17:0] bit_rate_value;
    logic        marker;
    logic [9:0]  vbv_size;
    logic        constrained;
    logic [5:0]  entry_index;
    logic [7:0]  entry_value;
    logic        last;
  } m2sh_res_t;

endpackage

// ===== rtl/core/m2sh_if.sv =====
// Valid/ready channel interfaces for the byte input and the result output.
interface m2sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink (input valid, input data_byte, input first, output ready);
endinterface

interface m2sh_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] pic_width;
  logic [11:0] pic_height;
  logic [3:0]  aspect_code;
  logic [3:0]  rate_code;
  logic [17:0] bit_rate_value;
  logic        marker;
  logic [9:0]  vbv_size;
  logic        constrained;
  logic [5:0]  entry_index;
  logic [7:0]  entry_value;
  logic        last;

  modport source (
    output valid, output kind, output pic_width, output pic_height, output aspect_code,
    output rate_code, output bit_rate_value, output marker, output vbv_size,
    output constrained, output entry_index, output entry_value, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input pic_width, input pic_height, input aspect_code,
    input rate_code, input bit_rate_value, input marker, input vbv_size,
    input constrained, input entry_index, input entry_value, input last,
    output ready
  );
endinterface

// ===== rtl/core/m2sh_in_stage.sv =====
// Input register stage holding one byte transaction.
module m2sh_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  m2sh_pkg::m2sh_item_t item_i,
  output logic                valid_o,
  input  logic                take_i,
  output m2sh_pkg::m2sh_item_t item_o
);
  import m2sh_pkg::*;

  logic       valid_q;
  m2sh_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== rtl/core/m2sh_parse.sv =====
// Parse state, field extraction and result register.
module m2sh_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  m2sh_pkg::m2sh_item_t item_i,
  output logic                 take_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output m2sh_pkg::m2sh_res_t  res_o
);
  import m2sh_pkg::*;

  localparam logic [1:0] SEC_HDR      = 2'd0;
  localparam logic [1:0] SEC_INTRA    = 2'd1;
  localparam logic [1:0] SEC_NONINTRA = 2'd2;

  logic            active_q, active_d;
  logic [1:0]      sec_q, sec_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      prev_q, prev_d;
  logic [7:0]      hdr_q [HdrBytes-1];
  logic            hdr_we;

  logic            res_valid_q;
  m2sh_res_t       res_q, res_d;
  logic            has_res;
  logic            slot_free;

  logic            eff_active;
  logic [1:0]      eff_sec;
  logic [PosW-1:0] eff_pos;
  logic [7:0]      b;

  assign slot_free   = !res_valid_q || res_ready_i;
  assign take_o      = valid_i && slot_free;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign b          = item_i.data_byte;
  assign eff_active = item_i.first || active_q;
  assign eff_sec    = item_i.first ? SEC_HDR : sec_q;
  assign eff_pos    = item_i.first ? '0 : pos_q;

  always_comb begin
    res_d    = '0;
    has_res  = 1'b0;
    hdr_we   = 1'b0;
    active_d = active_q;
    sec_d    = sec_q;
    pos_d    = pos_q;
    prev_d   = prev_q;
    if (take_o && eff_active) begin
      active_d = 1'b1;
      sec_d    = eff_sec;
      pos_d    = eff_pos;
      case (eff_sec)
        SEC_HDR: begin
          if (eff_pos[2:0] != 3'd7) begin
            hdr_we = 1'b1;
            pos_d  = eff_pos + PosW'(1);
          end else begin
            has_res              = 1'b1;
            res_d.kind           = KIND_HDR;
            res_d.pic_width      = {hdr_q[0], hdr_q[1][7:4]};
            res_d.pic_height     = {hdr_q[1][3:0], hdr_q[2]};
            res_d.aspect_code    = hdr_q[3][7:4];
            res_d.rate_code      = hdr_q[3][3:0];
            res_d.bit_rate_value = {hdr_q[4], hdr_q[5], hdr_q[6][7:6]};
            res_d.marker         = hdr_q[6][5];
            res_d.vbv_size       = {hdr_q[6][4:0], b[7:3]};
            res_d.constrained    = b[2];
            res_d.last           = !b[1] && !b[0];
            prev_d               = b;
            pos_d                = '0;
            if (b[1]) begin
              sec_d = SEC_INTRA;
            end else if (b[0]) begin
              sec_d = SEC_NONINTRA;
            end else begin
              sec_d    = SEC_HDR;
              active_d = 1'b0;
            end
          end
        end
        SEC_INTRA: begin
          has_res           = 1'b1;
          res_d.kind        = KIND_INTRA;
          res_d.entry_index = eff_pos;
          res_d.entry_value = {prev_q[0], b[7:1]};
          prev_d            = b;
          pos_d             = eff_pos + PosW'(1);
          if (&eff_pos) begin
            res_d.last = !b[0];
            if (b[0]) begin
              sec_d = SEC_NONINTRA;
            end else begin
              sec_d    = SEC_HDR;
              active_d = 1'b0;
            end
          end
        end
        SEC_NONINTRA: begin
          has_res           = 1'b1;
          res_d.kind        = KIND_NONINTRA;
          res_d.entry_index = eff_pos;
          res_d.entry_value = b;
          pos_d             = eff_pos + PosW'(1);
          if (&eff_pos) begin
            res_d.last = 1'b1;
            sec_d      = SEC_HDR;
            active_d   = 1'b0;
          end
        end
        default: begin
          active_d = 1'b0;
          sec_d    = SEC_HDR;
          pos_d    = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      sec_q       <= SEC_HDR;
      pos_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      sec_q    <= sec_d;
      pos_q    <= pos_d;
      if (slot_free) begin
        res_valid_q <= take_o && has_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    if (hdr_we) begin
      hdr_q[eff_pos[2:0]] <= b;
    end
    if (take_o && has_res) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== rtl/core/mpeg2_sequence_header_parser.sv =====
// Top level of the MPEG-2 sequence header parser.
// Each byte passes the input register stage and then the result register before its result is valid.
// Throughput: one byte per cycle unless the output stalls; at most one result per byte.
// Back pressure on the output stalls the input register stage.
// Reset (rst_ni low, asynchronous) empties both stages and leaves the parser
// idle, waiting for a byte flagged as first.
module mpeg2_sequence_header_parser (
  input  logic clk_i,
  input  logic rst_ni,
  m2sh_in_if.sink    in_i,
  m2sh_out_if.source out_o
);
  import m2sh_pkg::*;

  m2sh_item_t in_item;
  m2sh_item_t stg_item;
  logic       stg_valid;
  logic       stg_take;
  m2sh_res_t  res;

  assign in_item.data_byte = in_i.data_byte;
  assign in_item.first     = in_i.first;

  m2sh_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (stg_valid),
    .take_i  (stg_take),
    .item_o  (stg_item)
  );

  m2sh_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stg_valid),
    .item_i      (stg_item),
    .take_o      (stg_take),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign out_o.kind           = res.kind;
  assign out_o.pic_width      = res.pic_width;
  assign out_o.pic_height     = res.pic_height;
  assign out_o.aspect_code    = res.aspect_code;
  assign out_o.rate_code      = res.rate_code;
  assign out_o.bit_rate_value = res.bit_rate_value;
  assign out_o.marker         = res.marker;
  assign out_o.vbv_size       = res.vbv_size;
  assign out_o.constrained    = res.constrained;
  assign out_o.entry_index    = res.entry_index;
  assign out_o.entry_value    = res.entry_value;
  assign out_o.last           = res.last;

endmodule

// ===== rtl/core/m2sh_checker.sv =====
// Port-level assertions for the sequence header parser, bound to the top level.
module m2sh_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i,
  input logic [5:0] out_entry_index_i,
  input logic [7:0] out_entry_value_i,
  input logic [11:0] out_pic_width_i,
  input logic [17:0] out_bit_rate_value_i,
  input logic       out_last_i
);
  import m2sh_pkg::*;

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i)
      && $stable(out_entry_value_i))
    else $error("stalled result transaction changed");

  a_hdr_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_HDR |-> out_entry_index_i == '0
      && out_entry_value_i == '0)
    else $error("header result carries matrix entry bits");

  a_entry_hdr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_INTRA || out_kind_i == KIND_NONINTRA)
      |-> out_pic_width_i == '0 && out_bit_rate_value_i == '0)
    else $error("matrix result carries header fields");

  a_matrix_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i && out_kind_i != KIND_HDR |-> &out_entry_index_i)
    else $error("matrix ended before its final entry");

endmodule

bind mpeg2_sequence_header_parser m2sh_checker u_m2sh_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_kind_i           (out_o.kind),
  .out_entry_index_i    (out_o.entry_index),
  .out_entry_value_i    (out_o.entry_value),
  .out_pic_width_i      (out_o.pic_width),
  .out_bit_rate_value_i (out_o.bit_rate_value),
  .out_last_i           (out_o.last)
);

// ===== dv/tb_mpeg2_sequence_header_parser.sv =====
// Testbench for the MPEG-2 sequence header parser: directed and random byte streams checked against a predictor.
`timescale 1ns / 100ps

module tb_mpeg2_sequence_header_parser;
  import m2sh_pkg::*;

  typedef enum logic [1:0] {
    SEC_HDR,
    SEC_INTRA,
    SEC_NONINTRA
  } parse_sec_e;

  localparam int unsigned PipeDelay  = 8;
  localparam int unsigned DrainLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni;

  m2sh_in_if  in_if ();
  m2sh_out_if out_if ();

  mpeg2_sequence_header_parser i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  logic             parsing;
  parse_sec_e       sec;
  logic [PosW-1:0]  pos;
  logic [7:0]       hdr_bytes [HdrBytes];
  logic [7:0]       prev_byte;
  m2sh_res_t        pending_results[$];
  int unsigned      parsed_bytes;

  int unsigned      src_idle_pct;
  int unsigned      snk_idle_pct;
  int unsigned      errors;
  int unsigned      mismatches;

  function automatic void predict_byte(logic [7:0] b, logic f);
    m2sh_res_t r;
    r = '0;
    if (f) begin
      parsing = 1'b1;
      sec     = SEC_HDR;
      pos     = '0;
    end
    if (!parsing) return;
    parsed_bytes++;
    case (sec)
      SEC_HDR: begin
        hdr_bytes[pos[2:0]] = b;
        if (pos < HdrBytes - 1) begin
          pos++;
          return;
        end
        r.kind           = KIND_HDR;
        r.pic_width      = {hdr_bytes[0], hdr_bytes[1][7:4]};
        r.pic_height     = {hdr_bytes[1][3:0], hdr_bytes[2]};
        r.aspect_code    = hdr_bytes[3][7:4];
        r.rate_code      = hdr_bytes[3][3:0];
        r.bit_rate_value = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6][7:6]};
        r.marker         = hdr_bytes[6][5];
        r.vbv_size       = {hdr_bytes[6][4:0], hdr_bytes[7][7:3]};
        r.constrained    = hdr_bytes[7][2];
        r.last           = !b[1] && !b[0];
        prev_byte        = b;
        pos              = '0;
        if (b[1]) sec = SEC_INTRA;
        else if (b[0]) sec = SEC_NONINTRA;
        else begin
          parsing = 1'b0;
          sec     = SEC_HDR;
        end
      end
      SEC_INTRA: begin
        r.kind        = KIND_INTRA;
        r.entry_index = pos;
        r.entry_value = {prev_byte[0], b[7:1]};
        prev_byte     = b;
        if (pos == PosW'(MatrixLen - 1)) begin
          r.last = !b[0];
          pos    = '0;
          if (b[0]) sec = SEC_NONINTRA;
          else begin
            parsing = 1'b0;
            sec     = SEC_HDR;
          end
        end else begin
          pos++;
        end
      end
      default: begin
        r.kind        = KIND_NONINTRA;
        r.entry_index = pos;
        r.entry_value = b;
        if (pos == PosW'(MatrixLen - 1)) begin
          r.last  = 1'b1;
          pos     = '0;
          parsing = 1'b0;
          sec     = SEC_HDR;
        end else begin
          pos++;
        end
      end
    endcase
    pending_results.push_back(r);
  endfunction

  function automatic string res_str(m2sh_res_t r);
    return $sformatf({"kind=%0d w=%0d h=%0d asp=%0d rate=%0d br=%0d mk=%0b vbv=%0d ",
                      "cp=%0b idx=%0d val=%0d last=%0b"},
                     r.kind, r.pic_width, r.pic_height, r.aspect_code, r.rate_code,
                     r.bit_rate_value, r.marker, r.vbv_size, r.constrained,
                     r.entry_index, r.entry_value, r.last);
  endfunction

  // Output side: random back pressure and result checking
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    m2sh_res_t got;
    m2sh_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.kind           = out_if.kind;
      got.pic_width      = out_if.pic_width;
      got.pic_height     = out_if.pic_height;
      got.aspect_code    = out_if.aspect_code;
      got.rate_code      = out_if.rate_code;
      got.bit_rate_value = out_if.bit_rate_value;
      got.marker         = out_if.marker;
      got.vbv_size       = out_if.vbv_size;
      got.constrained    = out_if.constrained;
      got.entry_index    = out_if.entry_index;
      got.entry_value    = out_if.entry_value;
      got.last           = out_if.last;
      if (pending_results.size() == 0) begin
        errors++;
        if (++mismatches <= 10) $display("unexpected result: %s", res_str(got));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.pic_width !== want.pic_width ||
            got.pic_height !== want.pic_height || got.aspect_code !== want.aspect_code ||
            got.rate_code !== want.rate_code || got.bit_rate_value !== want.bit_rate_value ||
            got.marker !== want.marker || got.vbv_size !== want.vbv_size ||
            got.constrained !== want.constrained || got.entry_index !== want.entry_index ||
            got.entry_value !== want.entry_value || got.last !== want.last) begin
          errors++;
          if (++mismatches <= 10) begin
            $display("mismatch expected: %s", res_str(want));
            $display("         actual:   %s", res_str(got));
          end
        end
      end
    end
  end

  // Input side
  task automatic send_byte(input logic [7:0] b, input logic f);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.first     <= f;
    do @(posedge clk_i); while (!in_if.ready);
    predict_byte(b, f);
  endtask

  task automatic wait_all_results();
    int unsigned n;
    in_if.valid <= 1'b0;
    n = 0;
    while (pending_results.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0d results never arrived", pending_results.size());
      pending_results.delete();
    end
    repeat (PipeDelay) @(posedge clk_i);
  endtask

  task automatic test_ignored_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_header_extremes();
    for (int i = 0; i < HdrBytes; i++) send_byte(8'h00, i == 0);
    send_byte(8'hA5, 1'b0);
    for (int i = 0; i < HdrBytes; i++) send_byte((i == HdrBytes - 1) ? 8'hFC : 8'hFF, i == 0);
  endtask

  task automatic test_restart_mid_header();
    for (int i = 0; i < 3; i++) send_byte(8'h5A, i == 0);
    for (int i = 0; i < HdrBytes; i++) send_byte(8'($urandom) & 8'hFC, i == 0);
  endtask

  task automatic send_random_header();
    logic        load_intra;
    logic        load_non;
    int unsigned total;
    int unsigned stop_at;
    logic [7:0]  b;
    load_intra = 1'($urandom_range(1));
    load_non   = 1'($urandom_range(1));
    total      = HdrBytes + (load_intra ? MatrixLen : 0) + (load_non ? MatrixLen : 0);
    stop_at    = ($urandom_range(9) == 0) ? $urandom_range(total - 1, 1) : total;
    for (int n = 0; n < stop_at; n++) begin
      b = 8'($urandom);
      if (n == HdrBytes - 1) begin
        b[1] = load_intra;
        if (!load_intra) b[0] = load_non;
      end
      if (load_intra && n == HdrBytes + MatrixLen - 1) b[0] = load_non;
      send_byte(b, n == 0);
    end
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic test_random_headers(input int unsigned src_pct, input int unsigned snk_pct,
                                     input int unsigned target);
    int unsigned start;
    int unsigned seqs;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start        = parsed_bytes;
    seqs         = 0;
    while (parsed_bytes - start < target) begin
      send_random_header();
      if (++seqs == 3) wait_all_results();
    end
    wait_all_results();
  endtask

  initial begin
    parsing         = 1'b0;
    sec             = SEC_HDR;
    pos             = '0;
    prev_byte       = '0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    parsed_bytes    = 0;
    errors          = 0;
    mismatches      = 0;
    src_idle_pct    = 32;
    snk_idle_pct    = 74;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.first     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ignored_bytes();
    test_header_extremes();
    test_restart_mid_header();
    wait_all_results();
    test_random_headers(32, 74, 530);
    test_random_headers(74, 32, 530);
    test_random_headers(0, 0, 530);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
